### src/tfab_pkg.sv
// Shared types, constants and color helpers for the texel filter / alpha blend block.
// Depends on nothing; every other file in src imports or references it.
package tfab_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int NSTAGE        = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;

  localparam logic [16:0] VPOS_ONE  = 17'h10000;
  localparam logic [16:0] ROUND_255 = 17'd127;
  localparam logic [15:0] MAX_5BIT  = 16'h001f;
  localparam logic [15:0] MAX_6BIT  = 16'h003f;
  localparam logic [7:0]  ALPHA_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS     = 3'd0,
    CFG_GLOBAL_OPACITY = 3'd1,
    CFG_START_OPACITY  = 3'd2,
    CFG_END_OPACITY    = 3'd3,
    CFG_BILINEAR_MODE  = 3'd4
  } cfg_idx_e;

  typedef logic [7:0] chan_t;
  typedef chan_t [2:0] rgb_t;

  // per-stage load enables and valid bits of the pipeline
  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } pipe_ctrl_t;

  // widen RGB565 to 8-bit channels by bit replication
  function automatic rgb_t expand565(logic [15:0] c);
    rgb_t ch;
    ch[0] = {c[15:11], c[15:13]};
    ch[1] = {c[10:5], c[10:9]};
    ch[2] = {c[4:0], c[4:2]};
    return ch;
  endfunction

  // rounded divide by 255: (x + 127) / 255 for x up to 255 * 255
  function automatic chan_t div255(logic [15:0] x);
    logic [16:0] y;
    logic [16:0] q;
    y = {1'b0, x} + ROUND_255;
    q = y + 17'd1 + (y >> 8);
    return q[15:8];
  endfunction

  // requantize 8-bit channels back to RGB565
  function automatic logic [15:0] pack565(rgb_t c);
    chan_t r;
    chan_t g;
    chan_t b;
    r = div255(16'(c[0]) * MAX_5BIT);
    g = div255(16'(c[1]) * MAX_6BIT);
    b = div255(16'(c[2]) * MAX_5BIT);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

endpackage

### src/tfab_if.sv
// Handshake channels of the texel filter / alpha blend block: fragment in, pixel out, config.
// Depends on tfab_pkg for the config index and data widths.
interface tfab_frag_if;
  logic        valid;
  logic        ready;
  logic [15:0] texel_top_left;
  logic [15:0] texel_top_right;
  logic [15:0] texel_bottom_left;
  logic [15:0] texel_bottom_right;
  logic [7:0]  frac_x;
  logic [7:0]  frac_y;
  logic [16:0] vertical_pos;
  logic [15:0] dest_pixel;

  modport source (
    output valid, texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right,
    output frac_x, frac_y, vertical_pos, dest_pixel,
    input  ready
  );
  modport sink (
    input  valid, texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right,
    input  frac_x, frac_y, vertical_pos, dest_pixel,
    output ready
  );
endinterface

interface tfab_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        blended;

  modport source (output valid, pixel_out, blended, input ready);
  modport sink (input valid, pixel_out, blended, output ready);
endinterface

interface tfab_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tfab_pkg::CFG_IDX_W-1:0]   index;
  logic [tfab_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/texel_filter_alpha_blend.sv
// Texel filter / alpha blend: five-stage pipeline, one fragment per cycle unless stalled.
// A fragment enters stage 0 at its input transfer and moves through stages 1 to 4 in order;
// each stage holds on stall and refills bubbles, so throughput
// is bounded only by output ready.
// Reset clears all stage valid bits and loads brightness, opacities and bilinear mode
// to their defaults; config writes are always accepted.
module texel_filter_alpha_blend #(
  parameter int FRAC_BITS = tfab_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tfab_frag_if.sink  in_i,
  tfab_cfg_if.sink   cfg_i,
  tfab_pix_if.source out_o
);
  import tfab_pkg::*;

  chan_t      bright_q;
  chan_t      global_q;
  chan_t      top_q;
  chan_t      bottom_q;
  logic       bilinear_q;
  pipe_ctrl_t pipe_ctrl;
  rgb_t       filt;
  chan_t      alpha;
  logic       in_acc;
  logic       out_acc;

  assign cfg_i.ready = 1'b1;

  // register file writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= ALPHA_MAX;
      global_q   <= ALPHA_MAX;
      top_q      <= ALPHA_MAX;
      bottom_q   <= ALPHA_MAX;
      bilinear_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BRIGHTNESS:     bright_q   <= cfg_i.data;
        CFG_GLOBAL_OPACITY: global_q   <= cfg_i.data;
        CFG_START_OPACITY:  top_q      <= cfg_i.data;
        CFG_END_OPACITY:    bottom_q   <= cfg_i.data;
        CFG_BILINEAR_MODE:  bilinear_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  tfab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .ctrl_o      (pipe_ctrl)
  );

  tfab_filter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_filter (
    .clk_i                (clk_i),
    .ctrl_i               (pipe_ctrl),
    .texel_top_left_i     (in_i.texel_top_left),
    .texel_top_right_i    (in_i.texel_top_right),
    .texel_bottom_left_i  (in_i.texel_bottom_left),
    .texel_bottom_right_i (in_i.texel_bottom_right),
    .frac_x_i             (in_i.frac_x),
    .frac_y_i             (in_i.frac_y),
    .bilinear_mode_i      (bilinear_q),
    .filt_o               (filt)
  );

  tfab_alpha u_alpha (
    .clk_i            (clk_i),
    .ctrl_i           (pipe_ctrl),
    .vertical_pos_i   (in_i.vertical_pos),
    .start_opacity_i  (top_q),
    .end_opacity_i    (bottom_q),
    .global_opacity_i (global_q),
    .alpha_o          (alpha)
  );

  tfab_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (pipe_ctrl),
    .filt_i       (filt),
    .alpha_i      (alpha),
    .dest_pixel_i (in_i.dest_pixel),
    .brightness_i (bright_q),
    .pixel_out_o  (out_o.pixel_out),
    .blended_o    (out_o.blended)
  );

  assign out_o.valid = pipe_ctrl.vld[NSTAGE-1];
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;

  // items in flight change only by input and output transfers
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(pipe_ctrl.vld) == $past($countones(pipe_ctrl.vld))
              + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("fragment count in pipeline inconsistent with transfers");

  // input backpressure only when the pipeline is full and the output stalls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready && pipe_ctrl.vld == '1))
    else $error("input stalled while pipeline has room");

  // an empty pipeline cannot present a result next cycle
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_ctrl.vld == '0) |=> !out_o.valid)
    else $error("result appeared from an empty pipeline");

endmodule

### src/tfab_ctrl.sv
// Valid/ready control of the fragment pipeline: per-stage valid bits and load enables.
// Depends on tfab_pkg.
module tfab_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output tfab_pkg::pipe_ctrl_t ctrl_o
);
  import tfab_pkg::*;

  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] vld_d;
  logic [NSTAGE:0]   rdy;

  // a stage may load when it is empty or its successor takes its item
  always_comb begin
    rdy[NSTAGE] = out_ready_i;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  // advance valid bits along with the data
  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctrl_o.en  = rdy[NSTAGE-1:0];
  assign ctrl_o.vld = vld_q;

endmodule

### src/tfab_alpha.sv
// Opacity path: vertical gradient between top and bottom opacity, then global opacity.
// Occupies pipeline stages 0 and 1; depends on tfab_pkg.
module tfab_alpha (
  input  logic                 clk_i,
  input  tfab_pkg::pipe_ctrl_t ctrl_i,
  input  logic [16:0]          vertical_pos_i,
  input  logic [7:0]           start_opacity_i,
  input  logic [7:0]           end_opacity_i,
  input  logic [7:0]           global_opacity_i,
  output logic [7:0]           alpha_o
);
  import tfab_pkg::*;

  logic [16:0] v_sat;
  logic [24:0] grad_sum;
  chan_t       grad_d;
  chan_t       grad_q;
  chan_t       alpha_q;

  // saturate position at one and interpolate the opacity
  always_comb begin
    v_sat    = (vertical_pos_i > VPOS_ONE) ? VPOS_ONE : vertical_pos_i;
    grad_sum = 25'(start_opacity_i) * 25'(VPOS_ONE - v_sat)
             + 25'(end_opacity_i) * 25'(v_sat) + 25'h8000;
    grad_d   = grad_sum[24] ? ALPHA_MAX : grad_sum[23:16];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      grad_q <= grad_d;
    end
    if (ctrl_i.en[1]) begin
      alpha_q <= div255(16'(global_opacity_i) * 16'(grad_q));
    end
  end

  assign alpha_o = alpha_q;

endmodule

### src/tfab_filter.sv
// Texel expansion and bilinear / nearest filtering, split horizontal then vertical.
// Occupies pipeline stages 0 and 1; depends on tfab_pkg.
module tfab_filter #(
  parameter int FRAC_BITS = tfab_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  tfab_pkg::pipe_ctrl_t ctrl_i,
  input  logic [15:0]          texel_top_left_i,
  input  logic [15:0]          texel_top_right_i,
  input  logic [15:0]          texel_bottom_left_i,
  input  logic [15:0]          texel_bottom_right_i,
  input  logic [7:0]           frac_x_i,
  input  logic [7:0]           frac_y_i,
  input  logic                 bilinear_mode_i,
  output tfab_pkg::rgb_t       filt_o
);
  import tfab_pkg::*;

  localparam int FW = (FRAC_BITS < 8) ? FRAC_BITS : 8;
  localparam int HW = 8 + FRAC_BITS;
  localparam int SW = 8 + 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [SW-1:0]      HALF = SW'(1) << (2 * FRAC_BITS - 1);

  rgb_t                 tl;
  rgb_t                 tr;
  rgb_t                 bl;
  rgb_t                 br;
  logic [FRAC_BITS:0]   fx;
  logic [FRAC_BITS:0]   wx;
  logic [FRAC_BITS:0]   fy;
  logic [FRAC_BITS:0]   wy;
  logic [2:0][HW-1:0]   top_d;
  logic [2:0][HW-1:0]   bot_d;
  logic [2:0][HW-1:0]   top_q;
  logic [2:0][HW-1:0]   bot_q;
  rgb_t                 near_q;
  logic [FRAC_BITS:0]   fy_q;
  logic [2:0][SW-1:0]   vsum;
  rgb_t                 filt_d;
  rgb_t                 filt_q;

  // horizontal lerp on the top and bottom rows
  always_comb begin
    tl = expand565(texel_top_left_i);
    tr = expand565(texel_top_right_i);
    bl = expand565(texel_bottom_left_i);
    br = expand565(texel_bottom_right_i);
    fx = (FRAC_BITS + 1)'(frac_x_i[FW-1:0]);
    wx = ONE - fx;
    fy = (FRAC_BITS + 1)'(frac_y_i[FW-1:0]);
    for (int c = 0; c < 3; c++) begin
      top_d[c] = HW'((HW + 1)'(tl[c]) * (HW + 1)'(wx) + (HW + 1)'(tr[c]) * (HW + 1)'(fx));
      bot_d[c] = HW'((HW + 1)'(bl[c]) * (HW + 1)'(wx) + (HW + 1)'(br[c]) * (HW + 1)'(fx));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      near_q <= tl;
      fy_q   <= fy;
    end
  end

  // vertical lerp with rounding, or pass the nearest texel
  always_comb begin
    wy = ONE - fy_q;
    for (int c = 0; c < 3; c++) begin
      vsum[c]   = SW'(top_q[c]) * SW'(wy) + SW'(bot_q[c]) * SW'(fy_q) + HALF;
      filt_d[c] = bilinear_mode_i ? vsum[c][2*FRAC_BITS +: 8] : near_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      filt_q <= filt_d;
    end
  end

  assign filt_o = filt_q;

endmodule

### src/tfab_blend.sv
// Brightness scale, alpha blend over the destination and RGB565 repack.
// Occupies pipeline stages 2 to 4 and carries the destination pixel; depends on tfab_pkg.
module tfab_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tfab_pkg::pipe_ctrl_t ctrl_i,
  input  tfab_pkg::rgb_t       filt_i,
  input  logic [7:0]           alpha_i,
  input  logic [15:0]          dest_pixel_i,
  input  logic [7:0]           brightness_i,
  output logic [15:0]          pixel_out_o,
  output logic                 blended_o
);
  import tfab_pkg::*;

  logic [3:0][15:0] dest_q;
  rgb_t             bright_d;
  rgb_t             bright_q;
  chan_t            alpha_q;
  rgb_t             dest_rgb;
  chan_t            inv_alpha;
  rgb_t             mix_d;
  rgb_t             mix_q;
  logic             zero_q;
  logic [15:0]      pixel_q;
  logic             blended_q;

  // carry the destination pixel alongside the fragment
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      dest_q[0] <= dest_pixel_i;
    end
    for (int k = 1; k < 4; k++) begin
      if (ctrl_i.en[k]) begin
        dest_q[k] <= dest_q[k-1];
      end
    end
  end

  // scale by brightness
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bright_d[c] = div255(16'(filt_i[c]) * 16'(brightness_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      bright_q <= bright_d;
      alpha_q  <= alpha_i;
    end
  end

  // blend over the destination; full alpha reduces to the color itself
  always_comb begin
    dest_rgb  = expand565(dest_q[2]);
    inv_alpha = ALPHA_MAX - alpha_q;
    for (int c = 0; c < 3; c++) begin
      mix_d[c] = div255(16'(bright_q[c]) * 16'(alpha_q) + 16'(dest_rgb[c]) * 16'(inv_alpha));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      mix_q  <= mix_d;
      zero_q <= (alpha_q == '0);
    end
  end

  // repack, or hand back the destination untouched when fully transparent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blended_q <= 1'b0;
    end else if (ctrl_i.en[4]) begin
      blended_q <= !zero_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      pixel_q <= zero_q ? dest_q[3] : pack565(mix_q);
    end
  end

  assign pixel_out_o = pixel_q;
  assign blended_o   = blended_q;

endmodule

### test/tb.sv
// Self-checking bench for texel_filter_alpha_blend: directed table, then random phases.
// Depends on tfab_pkg and the tfab_*_if interfaces; drives all three handshake channels
// and checks every output transfer against a typed result or a filter/blend predictor.
module tb;
  import tfab_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 250;
  localparam int PIPE_SLACK     = 2 * NSTAGE + 4;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] global_opacity;
    logic [7:0] start_opacity;
    logic [7:0] end_opacity;
    logic       bilinear;
  } regs_t;

  typedef struct packed {
    logic [15:0] tl;
    logic [15:0] tr;
    logic [15:0] bl;
    logic [15:0] br;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [16:0] vpos;
    logic [15:0] dest;
  } frag_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        blended;
  } pixel_t;

  typedef struct packed {
    regs_t  regs;
    frag_t  f;
    logic   typed;
    pixel_t want;
  } dir_row_t;

  localparam regs_t REGS_MAX = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
  localparam regs_t REGS_MIN = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};

  logic clk;
  logic rst_n;

  tfab_frag_if frag ();
  tfab_pix_if  pix ();
  tfab_cfg_if  cfg ();

  texel_filter_alpha_blend uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (frag),
    .cfg_i  (cfg),
    .out_o  (pix)
  );

  regs_t    cur_regs;
  pixel_t   expected_pixels[$];
  int       mismatches;
  int       quiet_cycles;
  int       hold_req;
  int       hold_seen;
  dir_row_t dir_rows[19];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // widen an RGB565 word to three 8-bit channels, red first
  function automatic logic [2:0][7:0] widen565(logic [15:0] c);
    logic [2:0][7:0] ch;
    ch[0] = {c[15:11], c[15:13]};
    ch[1] = {c[10:5], c[10:9]};
    ch[2] = {c[4:0], c[4:2]};
    return ch;
  endfunction

  // expected write-back pixel for one fragment under the given registers
  function automatic pixel_t blend_fragment(frag_t f, regs_t r);
    logic [2:0][7:0] t00, t01, t10, t11, dst;
    longint unsigned v, grad, alpha, fx, fy, one, acc, r5, g6, b5;
    longint unsigned ch [3];
    pixel_t res;
    one   = longint'(1) << FRAC;
    fx    = f.fx & (one - 1);
    fy    = f.fy & (one - 1);
    v     = (f.vpos > VPOS_ONE) ? VPOS_ONE : f.vpos;
    grad  = (r.start_opacity * (65536 - v) + r.end_opacity * v + 32768) >> 16;
    if (grad > 255) grad = 255;
    alpha = (r.global_opacity * grad + 127) / 255;
    // transparent: pass the destination through untouched
    if (alpha == 0) begin
      res.pixel   = f.dest;
      res.blended = 1'b0;
      return res;
    end
    t00 = widen565(f.tl);
    t01 = widen565(f.tr);
    t10 = widen565(f.bl);
    t11 = widen565(f.br);
    dst = widen565(f.dest);
    for (int i = 0; i < 3; i++) begin
      if (r.bilinear) begin
        acc = t00[i] * (one - fx) * (one - fy) + t01[i] * fx * (one - fy)
            + t10[i] * (one - fx) * fy + t11[i] * fx * fy + ((one * one) >> 1);
        ch[i] = acc >> (2 * FRAC);
      end else begin
        ch[i] = t00[i];
      end
      ch[i] = (ch[i] * r.brightness + 127) / 255;
      if (alpha != 255) ch[i] = (ch[i] * alpha + dst[i] * (255 - alpha) + 127) / 255;
    end
    r5 = (ch[0] * 31 + 127) / 255;
    g6 = (ch[1] * 63 + 127) / 255;
    b5 = (ch[2] * 31 + 127) / 255;
    res.pixel   = 16'((r5 << 11) | (g6 << 5) | b5);
    res.blended = 1'b1;
    return res;
  endfunction

  // pick an extreme or a random register level
  function automatic logic [7:0] level_pick();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // present one fragment from the falling edge until its transfer, then queue its result
  task automatic put_frag(frag_t f, logic typed, pixel_t want);
    @(negedge clk);
    frag.valid              <= 1'b1;
    frag.texel_top_left     <= f.tl;
    frag.texel_top_right    <= f.tr;
    frag.texel_bottom_left  <= f.bl;
    frag.texel_bottom_right <= f.br;
    frag.frac_x             <= f.fx;
    frag.frac_y             <= f.fy;
    frag.vertical_pos       <= f.vpos;
    frag.dest_pixel         <= f.dest;
    do @(posedge clk); while (!frag.ready);
    expected_pixels.push_back(typed ? want : blend_fragment(f, cur_regs));
  endtask

  // drop the fragment valid and wait until every queued result has come out
  task automatic drain_pipe();
    @(negedge clk);
    frag.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // one register write; returns at the rising edge of the transfer
  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_BRIGHTNESS:     cur_regs.brightness     = val;
      CFG_GLOBAL_OPACITY: cur_regs.global_opacity = val;
      CFG_START_OPACITY:  cur_regs.start_opacity  = val;
      CFG_END_OPACITY:    cur_regs.end_opacity    = val;
      CFG_BILINEAR_MODE:  cur_regs.bilinear       = val[0];
      default: ;
    endcase
  endtask

  // drain, then write the registers that differ (or all of them)
  task automatic program_regs(regs_t want, bit all);
    drain_pipe();
    if (all || want.brightness != cur_regs.brightness)
      write_reg(CFG_BRIGHTNESS, want.brightness);
    if (all || want.global_opacity != cur_regs.global_opacity)
      write_reg(CFG_GLOBAL_OPACITY, want.global_opacity);
    if (all || want.start_opacity != cur_regs.start_opacity)
      write_reg(CFG_START_OPACITY, want.start_opacity);
    if (all || want.end_opacity != cur_regs.end_opacity)
      write_reg(CFG_END_OPACITY, want.end_opacity);
    if (all || want.bilinear != cur_regs.bilinear)
      write_reg(CFG_BILINEAR_MODE, {7'd0, want.bilinear});
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // check each result transfer against the oldest queued expectation
  always @(posedge clk) begin
    pixel_t want;
    if (pix.valid && pix.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual pixel_out=%h blended=%b", $time,
                 pix.pixel_out, pix.blended);
      end else begin
        want = expected_pixels.pop_front();
        if (pix.pixel_out !== want.pixel) begin
          mismatches++;
          $display("%0t: pixel_out expected %h actual %h", $time, want.pixel, pix.pixel_out);
        end
        if (pix.blended !== want.blended) begin
          mismatches++;
          $display("%0t: blended expected %b actual %b", $time, want.blended, pix.blended);
        end
      end
    end
  end

  // end the run when no channel has moved a transfer for too long
  always @(posedge clk) begin
    if (!rst_n || (frag.valid && frag.ready) || (pix.valid && pix.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: stall at a rate that changes in runs, plus requested long hold-offs
  initial begin : pixel_drain
    int stall_pct;
    int run_left;
    int hold_left;
    pix.ready = 1'b0;
    hold_seen = 0;
    stall_pct = 0;
    run_left  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(200, 10);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      run_left--;
      if (hold_left > 0) begin
        hold_left--;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // directed fragments; rows with typed results are read straight off the spec
  initial begin
    // default registers: opaque, full brightness, bilinear
    dir_rows[0]  = '{REGS_MAX, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00,
                     17'h00000, 16'h0000}, 1'b1, '{16'hFFFF, 1'b1}};
    dir_rows[1]  = '{REGS_MAX, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 8'hFF,
                     17'h10000, 16'hFFFF}, 1'b1, '{16'h0000, 1'b1}};
    dir_rows[2]  = '{REGS_MAX, '{16'hF800, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00,
                     17'h08000, 16'h1234}, 1'b1, '{16'hF800, 1'b1}};
    dir_rows[3]  = '{REGS_MAX, '{16'hF800, 16'h07E0, 16'h001F, 16'hFFFF, 8'h80, 8'h80,
                     17'h08000, 16'h1234}, 1'b0, '0};
    dir_rows[4]  = '{REGS_MAX, '{16'h001F, 16'hF800, 16'h07E0, 16'h0000, 8'hFF, 8'h00,
                     17'h00001, 16'h0000}, 1'b0, '0};
    dir_rows[5]  = '{REGS_MAX, '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001, 8'h00, 8'hFF,
                     17'h0FFFF, 16'h0000}, 1'b0, '0};
    // position past one saturates
    dir_rows[6]  = '{REGS_MAX, '{16'h1357, 16'h2468, 16'hFEDC, 16'h8001, 8'h33, 8'hCC,
                     17'h1FFFF, 16'hAAAA}, 1'b0, '0};
    // nearest: top-left texel only
    dir_rows[7]  = '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0},
                     '{16'h07E0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h7F, 8'hC3,
                       17'h04000, 16'h0000}, 1'b1, '{16'h07E0, 1'b1}};
    // alpha zero from global opacity and from the gradient
    dir_rows[8]  = '{'{8'd255, 8'd0, 8'd255, 8'd255, 1'b1},
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h10, 8'h20,
                       17'h08000, 16'h5A5A}, 1'b1, '{16'h5A5A, 1'b0}};
    dir_rows[9]  = '{'{8'd255, 8'd255, 8'd0, 8'd0, 1'b1},
                     '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'h40, 8'h40,
                       17'h08000, 16'hA5A5}, 1'b1, '{16'hA5A5, 1'b0}};
    // gradient ends: transparent at the top, opaque at the bottom
    dir_rows[10] = '{'{8'd255, 8'd255, 8'd0, 8'd255, 1'b1},
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00,
                       17'h00000, 16'h0F0F}, 1'b1, '{16'h0F0F, 1'b0}};
    dir_rows[11] = '{'{8'd255, 8'd255, 8'd0, 8'd255, 1'b1},
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h55, 8'hAA,
                       17'h10000, 16'h0F0F}, 1'b1, '{16'hFFFF, 1'b1}};
    dir_rows[12] = '{'{8'd255, 8'd255, 8'd0, 8'd255, 1'b1},
                     '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 8'h01,
                       17'h1FFFF, 16'hFFFF}, 1'b1, '{16'h0000, 1'b1}};
    dir_rows[13] = '{'{8'd255, 8'd255, 8'd0, 8'd255, 1'b1},
                     '{16'hC618, 16'h39E7, 16'h8410, 16'h7BEF, 8'h21, 8'hE0,
                       17'h08000, 16'hF81F}, 1'b0, '0};
    // zero brightness: opaque black
    dir_rows[14] = '{'{8'd0, 8'd255, 8'd255, 8'd255, 1'b1},
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80, 8'h80,
                       17'h00000, 16'hFFFF}, 1'b1, '{16'h0000, 1'b1}};
    dir_rows[15] = '{'{8'd0, 8'd128, 8'd255, 8'd255, 1'b1},
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80, 8'h80,
                       17'h00000, 16'hFFFF}, 1'b0, '0};
    dir_rows[16] = '{'{8'd128, 8'd200, 8'd17, 8'd230, 1'b0},
                     '{16'h6B4D, 16'h0000, 16'hFFFF, 16'h1234, 8'h0F, 8'hF0,
                       17'h0C000, 16'h4208}, 1'b0, '0};
    // barely and almost opaque
    dir_rows[17] = '{'{8'd255, 8'd1, 8'd255, 8'd255, 1'b1},
                     '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00,
                       17'h00000, 16'hFFFF}, 1'b0, '0};
    dir_rows[18] = '{'{8'd255, 8'd254, 8'd255, 8'd255, 1'b1},
                     '{16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 8'hC0, 8'h40,
                       17'h10000, 16'h0000}, 1'b0, '0};
  end

  // reset, directed table, random phases, final verdict
  initial begin
    frag_t f;
    regs_t regs;
    int    burst_left;
    int    gap;
    rst_n                   = 1'b0;
    frag.valid              = 1'b0;
    frag.texel_top_left     = '0;
    frag.texel_top_right    = '0;
    frag.texel_bottom_left  = '0;
    frag.texel_bottom_right = '0;
    frag.frac_x             = '0;
    frag.frac_y             = '0;
    frag.vertical_pos       = '0;
    frag.dest_pixel         = '0;
    cfg.valid               = 1'b0;
    cfg.index               = CFG_BRIGHTNESS;
    cfg.data                = '0;
    cur_regs                = REGS_MAX;
    mismatches              = 0;
    hold_req                = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table, reprogramming when a row asks for other registers
    foreach (dir_rows[i]) begin
      if (dir_rows[i].regs != cur_regs) program_regs(dir_rows[i].regs, 1'b0);
      put_frag(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        regs = REGS_MAX;
      end else if (p == 1) begin
        regs = REGS_MIN;
      end else begin
        regs.brightness     = level_pick();
        regs.global_opacity = level_pick();
        regs.start_opacity  = level_pick();
        regs.end_opacity    = level_pick();
        regs.bilinear       = 1'($urandom);
      end
      program_regs(regs, p == 0);
      // back-pressure the output long enough for the pipeline to fill
      if (p == 2 || p == 5) hold_req++;
      burst_left = $urandom_range(60, 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        f.tl   = 16'($urandom);
        f.tr   = ($urandom_range(7) == 0) ? f.tl : 16'($urandom);
        f.bl   = 16'($urandom);
        f.br   = 16'($urandom);
        f.fx   = ($urandom_range(7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        f.fy   = ($urandom_range(7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        f.vpos = ($urandom_range(9) < 7) ? 17'($urandom_range(65536)) : 17'($urandom);
        f.dest = 16'($urandom);
        put_frag(f, 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          gap = $urandom_range(8, 1);
          repeat (gap) begin
            @(negedge clk);
            frag.valid <= 1'b0;
          end
          burst_left = $urandom_range(60, 1);
        end
      end
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/tfab_pkg.sv
src/tfab_if.sv
src/tfab_ctrl.sv
src/tfab_alpha.sv
src/tfab_filter.sv
src/tfab_blend.sv
src/texel_filter_alpha_blend.sv
test/tb.sv
